// ===== src/sorted_record_table_macros.svh =====
// Assertion macros for the sorted record table.
// Included by the RTL files that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SRT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define SRT_ASSERT(lbl, prop, msg)
`define SRT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/srt_pkg.sv =====
// Shared types and codes for the sorted record table.
// No dependencies; imported by srt_cell, srt_or_tree, sorted_record_table and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// Update commands broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

	// Per-cell comparison flags.
	typedef struct packed {
		logic lt;
		logic first;
		logic hit;
	} cell_flags_t;

	// Result fields gathered by the reduction tree.
	typedef struct packed {
		logic [5:0]  where;
		logic [31:0] key;
		logic [31:0] payload;
	} res_t;

endpackage
`default_nettype wire

// ===== src/sorted_record_table.sv =====
// Sorted record table: a row of CAPACITY cells kept in ascending signed key order.
// Each accepted transaction is reported on done once its result has passed every register level of the OR tree.
// Throughput: one transaction per cycle; every cell compares and shifts in the accept cycle,
// and the result is gathered by a pipelined OR tree, so busy is never raised.
// Reset (arst_n low, asynchronous) empties the table and drops results in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_record_table_macros.svh"
module sorted_record_table import srt_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] key,
	input  wire logic [31:0]        payload,
	input  wire logic [5:0]         position,
	output logic                    done,
	output logic [1:0]              status,
	output logic [5:0]              where,
	output logic signed [31:0]      found_key,
	output logic [31:0]             found_payload,
	output logic [6:0]              count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int LVLS = $clog2(CAPACITY);

	// Table occupancy; cells at or above this count hold stale data.
	logic [CW-1:0] count_q;

	logic                go;
	op_t                 op;
	logic                full;
	logic                found;
	logic                in_range;
	logic [KEY_BITS-1:0] new_key;
	logic [31:0]         new_key_out;
	cell_ctrl_t          ctrl;
	status_t             stat_now;
	logic [CW-1:0]       count_next;

	logic [KEY_BITS-1:0] cell_key_w  [CAPACITY];
	logic [31:0]         cell_pay_w  [CAPACITY];
	logic [31:0]         cell_kout_w [CAPACITY];
	cell_flags_t         flags_w     [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;
	res_t                leaf_w      [CAPACITY];
	res_t                root_w;

	// Result side information travels beside the reduction tree, one stage per level.
	logic          valid_s [LVLS];
	status_t       stat_s  [LVLS];
	logic [CW-1:0] cnt_s   [LVLS];

	assign busy     = 1'b0;
	assign go       = start && !busy;
	assign op       = op_t'(opcode);
	assign full     = (count_q == CW'(CAPACITY));
	assign in_range = (32'(position) < 32'(count_q));
	assign found    = |hit_vec;

	// The incoming key is brought to the stored width: sign-extended when wider,
	// cut to its low bits when narrower. The echoed key goes back out the same way.
	if (KEY_BITS > 32) begin : g_key_wide
		assign new_key     = {{(KEY_BITS-32){key[31]}}, key};
		assign new_key_out = new_key[31:0];
	end else if (KEY_BITS == 32) begin : g_key_same
		assign new_key     = key;
		assign new_key_out = new_key;
	end else begin : g_key_narrow
		assign new_key     = key[KEY_BITS-1:0];
		assign new_key_out = {{(32-KEY_BITS){new_key[KEY_BITS-1]}}, new_key};
	end

	assign ctrl.ins = go && (op == OP_INSERT) && !full;
	assign ctrl.del = go && (op == OP_DELETE) && found;

	always_comb begin
		case (op)
			OP_INSERT: stat_now = full ? ST_FULL : ST_DONE;
			OP_DELETE: stat_now = found ? ST_DONE : ST_NOT_FOUND;
			OP_READ:   stat_now = in_range ? ST_DONE : ST_RANGE;
			default:   stat_now = ST_DONE;
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.del) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// The cell row. Each cell looks only at its neighbors and at the broadcast command:
	// an insert shifts the cells from the insertion point one place up, and a delete
	// pulls the cells from the hit one place down.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                lt_left;
		logic [KEY_BITS-1:0] left_key;
		logic [31:0]         left_pay;
		logic [KEY_BITS-1:0] right_key;
		logic [31:0]         right_pay;
		logic                occupied;
		logic                sel_new;
		logic                sel_old;

		if (i == 0) begin : g_head
			assign lt_left  = 1'b1;
			assign left_key = new_key;
			assign left_pay = payload;
		end else begin : g_body
			assign lt_left  = flags_w[i-1].lt;
			assign left_key = cell_key_w[i-1];
			assign left_pay = cell_pay_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = cell_key_w[i];
			assign right_pay = cell_pay_w[i];
		end else begin : g_inner
			assign right_key = cell_key_w[i+1];
			assign right_pay = cell_pay_w[i+1];
		end

		assign occupied = (CW'(i) < count_q);

		srt_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.new_key       (new_key),
			.new_payload   (payload),
			.occupied      (occupied),
			.lt_left       (lt_left),
			.left_key      (left_key),
			.left_payload  (left_pay),
			.right_key     (right_key),
			.right_payload (right_pay),
			.flags         (flags_w[i]),
			.key_r         (cell_key_w[i]),
			.payload_r     (cell_pay_w[i])
		);

		assign hit_vec[i] = flags_w[i].hit;

		if (KEY_BITS >= 32) begin : g_kout_cut
			assign cell_kout_w[i] = cell_key_w[i][31:0];
		end else begin : g_kout_ext
			assign cell_kout_w[i] = {{(32-KEY_BITS){cell_key_w[i][KEY_BITS-1]}}, cell_key_w[i]};
		end

		// At most one cell is selected per transaction; everything else feeds zeros.
		assign sel_new = ctrl.ins && flags_w[i].first;
		assign sel_old = go && (((op == OP_DELETE) && flags_w[i].hit) ||
			((op == OP_READ) && occupied && (i < 64) && (position == 6'(i % 64))));

		assign leaf_w[i] = sel_new ? res_t'{6'(i % 64), new_key_out, payload} :
			sel_old ? res_t'{6'(i % 64), cell_kout_w[i], cell_pay_w[i]} : '0;
	end

	srt_or_tree #(
		.LEAVES (CAPACITY)
	) u_tree (
		.clk  (clk),
		.leaf (leaf_w),
		.root (root_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < LVLS; s++) begin
				valid_s[s] <= 1'b0;
			end
		end else begin
			valid_s[0] <= go;
			for (int s = 1; s < LVLS; s++) begin
				valid_s[s] <= valid_s[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		stat_s[0] <= stat_now;
		cnt_s[0]  <= count_next;
		for (int s = 1; s < LVLS; s++) begin
			stat_s[s] <= stat_s[s-1];
			cnt_s[s]  <= cnt_s[s-1];
		end
	end

	assign done          = valid_s[LVLS-1];
	assign status        = stat_s[LVLS-1];
	assign count         = 7'(cnt_s[LVLS-1]);
	assign where         = root_w.where;
	assign found_key     = root_w.key;
	assign found_payload = root_w.payload;

	`SRT_ASSERT(a_single_hit, $onehot0(hit_vec), "more than one cell matched a delete")
	`SRT_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "record count above capacity")
	`SRT_ASSERT_NEXT(a_del_shrinks, ctrl.del, count_q == $past(count_q) - CW'(1),
		"delete did not shrink table")
	`SRT_ASSERT_NEXT(a_full_holds, go && (op == OP_INSERT) && full, $stable(count_q),
		"refused insert changed count")
	`SRT_ASSERT(a_result_latency, go |-> ##LVLS done, "accepted transaction produced no result")

endmodule
`default_nettype wire

// ===== src/srt_cell.sv =====
// One storage cell of the sorted record table: holds a key and a payload.
// Depends on srt_pkg; instantiated in a row by sorted_record_table.
`timescale 1ns / 1ps
`default_nettype none
module srt_cell import srt_pkg::*; #(
	parameter int KEY_BITS = 32
) (
	input  wire logic                clk,
	input  wire cell_ctrl_t          ctrl,
	input  wire logic [KEY_BITS-1:0] new_key,
	input  wire logic [31:0]         new_payload,
	input  wire logic                occupied,
	input  wire logic                lt_left,
	input  wire logic [KEY_BITS-1:0] left_key,
	input  wire logic [31:0]         left_payload,
	input  wire logic [KEY_BITS-1:0] right_key,
	input  wire logic [31:0]         right_payload,
	output cell_flags_t              flags,
	output logic [KEY_BITS-1:0]      key_r,
	output logic [31:0]              payload_r
);

	logic [KEY_BITS-1:0] key_q;
	logic [31:0]         payload_q;

	// The cell is the insertion point when it is the first one whose key is not below
	// the new key; a delete hits only there and only on an exact match.
	always_comb begin
		flags.lt    = occupied && ($signed(key_q) < $signed(new_key));
		flags.first = !flags.lt && lt_left;
		flags.hit   = flags.first && occupied && (key_q == new_key);
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !flags.lt) begin
			key_q     <= lt_left ? new_key : left_key;
			payload_q <= lt_left ? new_payload : left_payload;
		end else if (ctrl.del && !flags.lt) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	assign key_r     = key_q;
	assign payload_r = payload_q;

endmodule
`default_nettype wire

// ===== src/srt_or_tree.sv =====
// Registered OR reduction tree that gathers the one selected cell's result.
// Depends on srt_pkg; one register level per tree level.
`timescale 1ns / 1ps
`default_nettype none
module srt_or_tree import srt_pkg::*; #(
	parameter int LEAVES = 64
) (
	input  wire logic clk,
	input  wire res_t leaf [LEAVES],
	output res_t      root
);

	localparam int LVLS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int N2   = 1 << LVLS;

	res_t pad_w  [N2];
	res_t node_q [N2-1];

	for (genvar j = 0; j < N2; j++) begin : g_pad
		if (j < LEAVES) begin : g_real
			assign pad_w[j] = leaf[j];
		end else begin : g_zero
			assign pad_w[j] = '0;
		end
	end

	// Heap layout: node n has children 2n+1 and 2n+2; the bottom row reads the leaves.
	for (genvar n = 0; n < N2 - 1; n++) begin : g_node
		if (2 * n + 1 >= N2 - 1) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[n] <= pad_w[2*n+1-(N2-1)] | pad_w[2*n+2-(N2-1)];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[n] <= node_q[2*n+1] | node_q[2*n+2];
			end
		end
	end

	assign root = node_q[0];

endmodule
`default_nettype wire

// ===== tb/sorted_record_table_checker.sv =====
// Scoreboard for the sorted record table: mirrors the table contents and checks every result.
// Depends on srt_pkg for the opcode and status codes; instantiated by sorted_record_table_test.
`timescale 1ns / 1ps
module sorted_record_table_checker import srt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] key,
	input  logic [31:0]        payload,
	input  logic [5:0]         position,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [5:0]         where,
	input  logic signed [31:0] found_key,
	input  logic [31:0]        found_payload,
	input  logic [6:0]         count,
	output int                 fail_count,
	output int                 pending
);

	localparam int SLOTS = 64;

	typedef struct {
		status_t            status;
		logic [5:0]         where;
		logic signed [31:0] key;
		logic [31:0]        payload;
		logic [6:0]         count;
	} table_report_t;

	logic signed [31:0] mirror_key [SLOTS];
	logic [31:0]        mirror_payload [SLOTS];
	int                 held;
	int                 results_seen;
	table_report_t      expected_reports [$];

	// Applies one command to the mirrored table and returns the report it should produce.
	function automatic table_report_t apply_command(op_t op, logic signed [31:0] k,
		logic [31:0] pay, logic [5:0] pos);
		table_report_t rep;
		int slot;
		rep.status  = ST_DONE;
		rep.where   = '0;
		rep.key     = '0;
		rep.payload = '0;
		slot = 0;
		case (op)
			OP_INSERT: begin
				if (held >= SLOTS) begin
					rep.status = ST_FULL;
				end else begin
					// New records go in front of equal keys.
					while (slot < held && mirror_key[slot] < k)
						slot++;
					for (int j = held; j > slot; j--) begin
						mirror_key[j]     = mirror_key[j - 1];
						mirror_payload[j] = mirror_payload[j - 1];
					end
					mirror_key[slot]     = k;
					mirror_payload[slot] = pay;
					held++;
					rep.where   = slot[5:0];
					rep.key     = k;
					rep.payload = pay;
				end
			end
			OP_DELETE: begin
				while (slot < held && mirror_key[slot] < k)
					slot++;
				if (slot < held && mirror_key[slot] == k) begin
					rep.where   = slot[5:0];
					rep.key     = mirror_key[slot];
					rep.payload = mirror_payload[slot];
					for (int j = slot; j < held - 1; j++) begin
						mirror_key[j]     = mirror_key[j + 1];
						mirror_payload[j] = mirror_payload[j + 1];
					end
					held--;
				end else begin
					rep.status = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (int'(pos) < held) begin
					rep.where   = pos;
					rep.key     = mirror_key[pos];
					rep.payload = mirror_payload[pos];
				end else begin
					rep.status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		rep.count = held[6:0];
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_report_t exp;
		if (!arst_n) begin
			held = 0;
			expected_reports.delete();
		end else begin
			if (done === 1'b1) begin
				results_seen++;
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d arrived with no transaction outstanding",
							results_seen);
				end else begin
					exp = expected_reports.pop_front();
					if (status !== exp.status || where !== exp.where ||
						found_key !== exp.key || found_payload !== exp.payload ||
						count !== exp.count) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("result %0d wrong: status %0d/%0d where %0d/%0d ",
								results_seen, exp.status, status, exp.where, where);
							$display("key %0d/%0d payload %h/%h count %0d/%0d (expected/got)",
								exp.key, found_key, exp.payload, found_payload,
								exp.count, count);
						end
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_reports.push_back(apply_command(op_t'(opcode), key, payload,
					position));
		end
		pending = expected_reports.size();
	end

endmodule

// ===== tb/sorted_record_table_test.sv =====
// Top of the sorted record table testbench: clock, reset, stimulus and the final verdict.
// Depends on srt_pkg, sorted_record_table and sorted_record_table_checker.
`timescale 1ns / 1ps
module sorted_record_table_test;
	import srt_pkg::*;

	// A run with no transaction moving for this many cycles is taken as hung.
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = OP_NOP;
	logic signed [31:0] key = '0;
	logic [31:0]        payload = '0;
	logic [5:0]         position = '0;
	logic               done;
	logic [1:0]         status;
	logic [5:0]         where;
	logic signed [31:0] found_key;
	logic [31:0]        found_payload;
	logic [6:0]         count;
	int                 fail_count;
	int                 pending;
	int                 stall_cycles = 0;

	sorted_record_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.key           (key),
		.payload       (payload),
		.position      (position),
		.done          (done),
		.status        (status),
		.where         (where),
		.found_key     (found_key),
		.found_payload (found_payload),
		.count         (count)
	);

	// The checker sees the same pins as the block and keeps the expected results.
	sorted_record_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.key           (key),
		.payload       (payload),
		.position      (position),
		.done          (done),
		.status        (status),
		.where         (where),
		.found_key     (found_key),
		.found_payload (found_payload),
		.count         (count),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: any cycle in which a transaction is taken or a result shows up counts as
	// progress. A long run of cycles without either means the block has hung.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog expired after %0d quiet cycles", stall_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Presents one transaction and holds it until the block takes it. It is entered and
	// left at a rising edge, so back-to-back calls keep start high without a glitch.
	task automatic send_command(input op_t op, input logic signed [31:0] k,
		input logic [31:0] pay, input logic [5:0] pos);
		start    <= 1'b1;
		opcode   <= op;
		key      <= k;
		payload  <= pay;
		position <= pos;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// One idle cycle. The fields carry junk while start is low; the block must ignore it.
	task automatic idle_cycle();
		start    <= 1'b0;
		opcode   <= 2'($urandom);
		key      <= $urandom;
		payload  <= $urandom;
		position <= 6'($urandom);
		@(posedge clk);
	endtask

	// Holds off the sender until every outstanding transaction has reported back.
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Most keys come from a small pool so that duplicates pile up and deletes find their
	// target; the rest are fully random so every key bit toggles.
	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(1, 100) > 75)
			return $urandom;
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return -32'sd1000;
			2:       return -32'sd7;
			3:       return -32'sd1;
			4:       return 32'sd0;
			5:       return 32'sd1;
			6:       return 32'sd2;
			7:       return 32'sd7;
			8:       return 32'sd42;
			9:       return 32'sd1000;
			10:      return 32'sh7fff_ffff;
			default: return 32'sh1234_5678;
		endcase
	endfunction

	// Picks an opcode for the current mode: filling drives the table up to full and keeps
	// knocking on it, draining pulls it back down, and the mixed mode wanders in between.
	function automatic op_t pick_op(int mode);
		int roll;
		roll = $urandom_range(1, 100);
		case (mode)
			0: begin
				if (roll <= 88) return OP_INSERT;
				if (roll <= 93) return OP_DELETE;
				if (roll <= 98) return OP_READ;
				return OP_NOP;
			end
			1: begin
				if (roll <= 20) return OP_INSERT;
				if (roll <= 85) return OP_DELETE;
				if (roll <= 97) return OP_READ;
				return OP_NOP;
			end
			default: begin
				if (roll <= 45) return OP_INSERT;
				if (roll <= 80) return OP_DELETE;
				if (roll <= 97) return OP_READ;
				return OP_NOP;
			end
		endcase
	endfunction

	initial begin
		int idle_pct;
		int mode;

		// Reset is held low from the start and released on a rising edge, once only.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions. The empty table must refuse a read and a delete, and a
		// do-nothing opcode only reports the count.
		send_command(OP_READ, 32'sd0, 32'd0, 6'd0);
		send_command(OP_DELETE, 32'sd5, 32'd0, 6'd0);
		send_command(OP_NOP, -32'sd1, 32'hffff_ffff, 6'd63);

		// Keys at both ends of the signed range, then a duplicate of zero, which has to
		// land in front of the zero already stored.
		send_command(OP_INSERT, 32'sd0, 32'h0000_0000, 6'd0);
		send_command(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 6'd63);
		send_command(OP_INSERT, 32'sh8000_0000, 32'h0000_0001, 6'd0);
		send_command(OP_INSERT, -32'sd1, 32'ha5a5_a5a5, 6'd0);
		send_command(OP_INSERT, 32'sd0, 32'h5a5a_5a5a, 6'd0);

		// Walk the table, then read just past the count and at the last position.
		for (int p = 0; p < 5; p++)
			send_command(OP_READ, 32'sd0, 32'd0, 6'(p));
		send_command(OP_READ, 32'sd0, 32'd0, 6'd5);
		send_command(OP_READ, 32'sd0, 32'd0, 6'd63);

		// Deleting zero takes the newer duplicate; an absent key between stored keys is
		// refused; the extreme keys are removed from both ends.
		send_command(OP_DELETE, 32'sd0, 32'd0, 6'd0);
		send_command(OP_DELETE, 32'sd1234, 32'd0, 6'd0);
		send_command(OP_DELETE, 32'sh8000_0000, 32'd0, 6'd0);
		send_command(OP_DELETE, 32'sh7fff_ffff, 32'd0, 6'd0);
		send_command(OP_READ, 32'sd0, 32'd0, 6'd0);

		// Let the pipeline run dry before the random part starts.
		wait_for_drain();

		// Random part in three stretches: the sender idles 19 percent of cycles, then 53
		// percent, then not at all. Modes change every hundred transactions so the table
		// goes full and back down several times.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_pct = (n < RANDOM_ITEMS / 3) ? 19 : (n < 2 * RANDOM_ITEMS / 3) ? 53 : 0;
			mode = (n / 100) % 3;
			if (n == RANDOM_ITEMS / 2)
				wait_for_drain();
			while ($urandom_range(1, 100) <= idle_pct)
				idle_cycle();
			send_command(pick_op(mode), pick_key(), $urandom, 6'($urandom_range(0, 63)));
		end

		// Wait for the last results, then let the clock run on to catch any stray strobe.
		wait_for_drain();
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
